/* sv/mexp_pkg.sv */
// shared types, constants and microcode table for the modular exponentiation unit
package mexp_pkg;

  localparam int WIDTH_DEF = 32;
  localparam int IO_W      = 32;
  localparam int PC_W      = 4;

  typedef enum logic [2:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_MZERO,
    JMP_EZERO,
    JMP_EBIT_CLR
  } jmp_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_REDUCE,
    MUL_ACC,
    MUL_SQR
  } mulop_t;

  typedef enum logic [1:0] {
    FIN_NONE,
    FIN_OK,
    FIN_ERR
  } fin_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_EXEC,
    SEQ_MWAIT,
    SEQ_DONE
  } seq_state_t;

  typedef struct packed {
    jmp_t            jmp;
    logic [PC_W-1:0] target;
    mulop_t          mul;
    logic            acc_one;
    logic            e_shift;
    fin_t            fin;
  } uword_t;

  typedef struct packed {
    logic   idle;
    logic   mul_start;
    mulop_t mul_op;
    logic   acc_one;
    logic   e_shift;
    logic   load_out;
    logic   err;
  } ctl_t;

  typedef struct packed {
    logic start;
    logic m_zero;
    logic e_zero;
    logic e_bit0;
    logic mul_done;
    logic out_free;
  } stat_t;

  localparam logic [PC_W-1:0] PC_CHK    = 4'd0;
  localparam logic [PC_W-1:0] PC_REDUCE = 4'd1;
  localparam logic [PC_W-1:0] PC_INIT   = 4'd2;
  localparam logic [PC_W-1:0] PC_LOOP   = 4'd3;
  localparam logic [PC_W-1:0] PC_TEST   = 4'd4;
  localparam logic [PC_W-1:0] PC_MUL    = 4'd5;
  localparam logic [PC_W-1:0] PC_SQR    = 4'd6;
  localparam logic [PC_W-1:0] PC_SHIFT  = 4'd7;
  localparam logic [PC_W-1:0] PC_FIN    = 4'd8;
  localparam logic [PC_W-1:0] PC_ERR    = 4'd9;

  function automatic uword_t uword(input jmp_t j, input logic [PC_W-1:0] t, input mulop_t m,
                                   input logic a1, input logic es, input fin_t f);
    uword_t w;
    w.jmp     = j;
    w.target  = t;
    w.mul     = m;
    w.acc_one = a1;
    w.e_shift = es;
    w.fin     = f;
    return w;
  endfunction

  // microcode program
  function automatic uword_t rom_word(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      PC_CHK:    w = uword(JMP_MZERO,    PC_ERR,  MUL_NONE,   1'b0, 1'b0, FIN_NONE);
      PC_REDUCE: w = uword(JMP_NONE,     PC_CHK,  MUL_REDUCE, 1'b0, 1'b0, FIN_NONE);
      PC_INIT:   w = uword(JMP_NONE,     PC_CHK,  MUL_NONE,   1'b1, 1'b0, FIN_NONE);
      PC_LOOP:   w = uword(JMP_EZERO,    PC_FIN,  MUL_NONE,   1'b0, 1'b0, FIN_NONE);
      PC_TEST:   w = uword(JMP_EBIT_CLR, PC_SQR,  MUL_NONE,   1'b0, 1'b0, FIN_NONE);
      PC_MUL:    w = uword(JMP_NONE,     PC_CHK,  MUL_ACC,    1'b0, 1'b0, FIN_NONE);
      PC_SQR:    w = uword(JMP_NONE,     PC_CHK,  MUL_SQR,    1'b0, 1'b0, FIN_NONE);
      PC_SHIFT:  w = uword(JMP_ALWAYS,   PC_LOOP, MUL_NONE,   1'b0, 1'b1, FIN_NONE);
      PC_FIN:    w = uword(JMP_NONE,     PC_CHK,  MUL_NONE,   1'b0, 1'b0, FIN_OK);
      PC_ERR:    w = uword(JMP_NONE,     PC_CHK,  MUL_NONE,   1'b0, 1'b0, FIN_ERR);
      default:   w = uword(JMP_NONE,     PC_CHK,  MUL_NONE,   1'b0, 1'b0, FIN_ERR);
    endcase
    return w;
  endfunction

endpackage

/* sv/mexp_mulmod.sv */
// shift-add modular multiplier, one multiplier bit per cycle
module mexp_mulmod #(
  parameter int WIDTH = mexp_pkg::WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  input  logic [WIDTH-1:0] m,
  output logic             done,
  output logic [WIDTH-1:0] result
);

  localparam int CNT_W = $clog2(WIDTH);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WIDTH-1:0] r_r, r_nxt;
  logic [WIDTH-1:0] x_r, x_nxt;
  logic [WIDTH-1:0] y_r, y_nxt;
  logic [WIDTH-1:0] m_r, m_nxt;
  logic [WIDTH:0]   dbl, dbl_red, sum, sum_red;

  // r = 2r + bit*x, the doubling and the addition each kept below m with one conditional subtract
  always_comb begin
    dbl     = {r_r, 1'b0};
    dbl_red = (dbl >= {1'b0, m_r}) ? dbl - {1'b0, m_r} : dbl;
    sum     = {1'b0, dbl_red[WIDTH-1:0]} + (y_r[WIDTH-1] ? {1'b0, x_r} : '0);
    sum_red = (sum >= {1'b0, m_r}) ? sum - {1'b0, m_r} : sum;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    r_nxt    = r_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    m_nxt    = m_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      r_nxt    = '0;
      x_nxt    = x;
      y_nxt    = y;
      m_nxt    = m;
    end else if (busy_r) begin
      r_nxt   = sum_red[WIDTH-1:0];
      y_nxt   = {y_r[WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    r_r <= r_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    m_r <= m_nxt;
  end

  assign done   = done_r;
  assign result = r_r;

  a_done_after_busy : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("multiplier done without a running operation");

  a_done_not_busy : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("multiplier busy and done together");

  a_result_reduced : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (r_r < m_r))
    else $error("multiplier result not below modulus");

endmodule

/* sv/mexp_seq.sv */
// microcode sequencer: step counter, control table and conditional jumps
module mexp_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  mexp_pkg::stat_t stat,
  output mexp_pkg::ctl_t  ctl
);

  mexp_pkg::seq_state_t         state_r, state_nxt;
  logic [mexp_pkg::PC_W-1:0]    pc_r, pc_nxt;
  mexp_pkg::uword_t             w;
  logic                         taken;

  assign w = mexp_pkg::rom_word(pc_r);

  always_comb begin
    case (w.jmp)
      mexp_pkg::JMP_ALWAYS:   taken = 1'b1;
      mexp_pkg::JMP_MZERO:    taken = stat.m_zero;
      mexp_pkg::JMP_EZERO:    taken = stat.e_zero;
      mexp_pkg::JMP_EBIT_CLR: taken = !stat.e_bit0;
      default:                taken = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    case (state_r)
      mexp_pkg::SEQ_IDLE: begin
        if (stat.start) begin
          state_nxt = mexp_pkg::SEQ_EXEC;
          pc_nxt    = mexp_pkg::PC_CHK;
        end
      end
      mexp_pkg::SEQ_EXEC: begin
        if (w.fin != mexp_pkg::FIN_NONE) begin
          state_nxt = mexp_pkg::SEQ_DONE;
        end else begin
          if (w.mul != mexp_pkg::MUL_NONE) state_nxt = mexp_pkg::SEQ_MWAIT;
          pc_nxt = taken ? w.target : pc_r + 1'b1;
        end
      end
      mexp_pkg::SEQ_MWAIT: begin
        if (stat.mul_done) state_nxt = mexp_pkg::SEQ_EXEC;
      end
      mexp_pkg::SEQ_DONE: begin
        if (stat.out_free) state_nxt = mexp_pkg::SEQ_IDLE;
      end
      default: state_nxt = mexp_pkg::SEQ_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl = '0;
    ctl.mul_op = mexp_pkg::MUL_NONE;
    case (state_r)
      mexp_pkg::SEQ_IDLE: begin
        ctl.idle = 1'b1;
      end
      mexp_pkg::SEQ_EXEC: begin
        ctl.mul_start = (w.fin == mexp_pkg::FIN_NONE) && (w.mul != mexp_pkg::MUL_NONE);
        ctl.mul_op    = w.mul;
        ctl.acc_one   = w.acc_one;
        ctl.e_shift   = w.e_shift;
      end
      mexp_pkg::SEQ_DONE: begin
        ctl.load_out = stat.out_free;
        ctl.err      = (w.fin == mexp_pkg::FIN_ERR);
      end
      default: ctl.idle = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mexp_pkg::SEQ_IDLE;
      pc_r    <= mexp_pkg::PC_CHK;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

endmodule

/* sv/modular_exponentiation_unit.sv */
// Computes base^exponent mod modulus by right-to-left square-and-multiply under microcode
// control. One item is worked on at a time; the next can be taken as soon as the result
// is in the output register. The time per item is set by the shared modular multiplier,
// which handles one multiplier bit per cycle, and by the work per item: a base reduction,
// then for each exponent bit up to the highest set one a square and, for a set bit, a
// multiply, plus the loop test, bit test and shift steps of the sequencer for each bit.
// Only the low WIDTH bits of each input are used.
module modular_exponentiation_unit #(
  parameter int WIDTH = mexp_pkg::WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [mexp_pkg::IO_W-1:0] in_base_value,
  input  logic [mexp_pkg::IO_W-1:0] in_exponent,
  input  logic [mexp_pkg::IO_W-1:0] in_modulus,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [mexp_pkg::IO_W-1:0] out_power_result,
  output logic                      out_zero_modulus_error
);

  mexp_pkg::ctl_t  ctl;
  mexp_pkg::stat_t stat;

  logic [WIDTH-1:0]          b_r, b_nxt;
  logic [WIDTH-1:0]          e_r, e_nxt;
  logic [WIDTH-1:0]          m_r, m_nxt;
  logic [WIDTH-1:0]          acc_r, acc_nxt;
  mexp_pkg::mulop_t          dest_r, dest_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [mexp_pkg::IO_W-1:0] res_r, res_nxt;
  logic                      err_r, err_nxt;

  logic             in_take;
  logic [WIDTH-1:0] mul_x, mul_y, mul_res;
  logic             mul_done;

  assign in_stall = !ctl.idle;
  assign in_take  = in_valid && ctl.idle;

  always_comb begin
    stat.start    = in_take;
    stat.m_zero   = (m_r == '0);
    stat.e_zero   = (e_r == '0);
    stat.e_bit0   = e_r[0];
    stat.mul_done = mul_done;
    stat.out_free = !out_valid_r || !out_stall;
  end

  mexp_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  always_comb begin
    case (ctl.mul_op)
      mexp_pkg::MUL_REDUCE: begin
        mul_x = WIDTH'(1);
        mul_y = b_r;
      end
      mexp_pkg::MUL_ACC: begin
        mul_x = b_r;
        mul_y = acc_r;
      end
      default: begin
        mul_x = b_r;
        mul_y = b_r;
      end
    endcase
  end

  mexp_mulmod #(.WIDTH(WIDTH)) u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ctl.mul_start),
    .x      (mul_x),
    .y      (mul_y),
    .m      (m_r),
    .done   (mul_done),
    .result (mul_res)
  );

  always_comb begin
    b_nxt    = b_r;
    e_nxt    = e_r;
    m_nxt    = m_r;
    acc_nxt  = acc_r;
    dest_nxt = dest_r;
    if (in_take) begin
      b_nxt = in_base_value[WIDTH-1:0];
      e_nxt = in_exponent[WIDTH-1:0];
      m_nxt = in_modulus[WIDTH-1:0];
    end
    if (ctl.acc_one) acc_nxt = WIDTH'(1);
    if (ctl.e_shift) e_nxt = e_r >> 1;
    if (ctl.mul_start) dest_nxt = ctl.mul_op;
    if (mul_done) begin
      case (dest_r)
        mexp_pkg::MUL_ACC: acc_nxt = mul_res;
        default:           b_nxt   = mul_res;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    err_nxt       = err_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (ctl.load_out) begin
      out_valid_nxt = 1'b1;
      res_nxt       = ctl.err ? '0 : mexp_pkg::IO_W'(acc_r);
      err_nxt       = ctl.err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      dest_r      <= mexp_pkg::MUL_NONE;
    end else begin
      out_valid_r <= out_valid_nxt;
      dest_r      <= dest_nxt;
    end
    b_r   <= b_nxt;
    e_r   <= e_nxt;
    m_r   <= m_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
    err_r <= err_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_power_result       = res_r;
  assign out_zero_modulus_error = err_r;

  a_err_zero_result : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && err_r) |-> (res_r == '0))
    else $error("error item with nonzero result");

  a_load_needs_room : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_out |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a waiting item");

  a_no_take_while_mul : assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> !ctl.mul_start)
    else $error("item taken while a product is being started");

endmodule

/* dv/tb_top.sv */
// self-checking testbench for the modular exponentiation unit
`timescale 1ns / 100ps

module tb_top;

  localparam int IO_W = mexp_pkg::IO_W;
  localparam int OPW = mexp_pkg::WIDTH_DEF;
  localparam logic [63:0] OP_MASK = (64'd1 << OPW) - 64'd1;
  localparam int LIMIT = 4_000_000;
  localparam int HOLD_AT = 60;
  localparam int HOLD_CYCLES = 8000;
  localparam int TAIL = 30;
  localparam int N_RANDOM = 254;
  localparam logic [IO_W-1:0] ALL1 = '1;

  typedef struct packed {
    logic [IO_W-1:0] base_value;
    logic [IO_W-1:0] exponent;
    logic [IO_W-1:0] modulus;
  } operand_t;

  typedef struct packed {
    logic [IO_W-1:0] power_result;
    logic            zero_modulus_error;
  } power_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [IO_W-1:0] in_base_value = '0;
  logic [IO_W-1:0] in_exponent = '0;
  logic [IO_W-1:0] in_modulus = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [IO_W-1:0] out_power_result;
  logic            out_zero_modulus_error;

  operand_t operand_q[$];
  power_t   power_q[$];
  logic     in_fire = 1'b0;
  int       total_items = 0;
  int       in_taken_cnt = 0;
  int       out_cnt = 0;
  int       err_cnt = 0;
  int       cycle_cnt = 0;
  int       idle_pct = 10;
  int       gap_left = 0;
  int       stall_left = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;

  modular_exponentiation_unit u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_base_value          (in_base_value),
    .in_exponent            (in_exponent),
    .in_modulus             (in_modulus),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_power_result       (out_power_result),
    .out_zero_modulus_error (out_zero_modulus_error)
  );

  always #5 clk = ~clk;

  function automatic power_t mod_pow(input operand_t op);
    logic [63:0] b;
    logic [63:0] e;
    logic [63:0] m;
    logic [63:0] acc;
    power_t      r;
    b = {32'd0, op.base_value} & OP_MASK;
    e = {32'd0, op.exponent} & OP_MASK;
    m = {32'd0, op.modulus} & OP_MASK;
    if (m == 64'd0) begin
      r.power_result = '0;
      r.zero_modulus_error = 1'b1;
      return r;
    end
    acc = 64'd1;
    b = b % m;
    for (int i = 0; i < OPW; i++) begin
      if (e == 64'd0) break;
      if (e[0]) acc = (acc * b) % m;
      b = (b * b) % m;
      e = e >> 1;
    end
    r.power_result = acc[IO_W-1:0];
    r.zero_modulus_error = 1'b0;
    return r;
  endfunction

  task automatic add_item(input logic [IO_W-1:0] b, input logic [IO_W-1:0] e,
                          input logic [IO_W-1:0] m);
    operand_t op;
    op.base_value = b;
    op.exponent = e;
    op.modulus = m;
    operand_q.push_back(op);
  endtask

  // stimulus and end of run
  initial begin
    logic [IO_W-1:0] b;
    logic [IO_W-1:0] e;
    logic [IO_W-1:0] m;
    int              pick;
    int              len;

    add_item(32'd0, 32'd0, 32'd0);
    add_item(ALL1, ALL1, 32'd0);
    add_item(32'd5, 32'd0, 32'd0);
    add_item(32'd9, 32'd0, 32'd1);
    add_item(ALL1, 32'd0, ALL1);
    add_item(32'd77, 32'd5, 32'd1);
    add_item(ALL1, ALL1, 32'd1);
    add_item(32'd0, 32'd1, 32'd7);
    add_item(32'd7, 32'd1, 32'd2);
    add_item(32'd2, 32'd10, 32'd1000);
    add_item(ALL1, 32'd2, ALL1);
    add_item(32'h8000_0000, 32'd2, ALL1);
    add_item(ALL1, 32'd3, 32'h8000_0000);
    add_item(ALL1, ALL1, ALL1);
    add_item(32'd3, ALL1, 32'hFFFF_FFFB);
    add_item(32'd12345, 32'h8000_0000, 32'h7FFF_FFFF);
    add_item(32'hDEAD_BEEF, 32'hAAAA_5555, 32'hFFFF_FFFE);

    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) b = $urandom();
      else b = $urandom_range(0, 300);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        e = $urandom();
      end else if (pick < 20) begin
        e = '0;
      end else begin
        len = $urandom_range(1, 8);
        e = $urandom() & ((32'd1 << len) - 32'd1);
      end
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        m = '0;
      end else if (pick < 12) begin
        m = $urandom_range(1, 3);
      end else if (pick < 30) begin
        len = $urandom_range(2, 31);
        m = $urandom() & ((32'd1 << len) - 32'd1);
      end else begin
        m = $urandom();
      end
      add_item(b, e, m);
    end
    total_items = operand_q.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (in_taken_cnt < total_items) @(posedge clk);
    while (power_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog and idle-rate changes
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt % 800 == 0) begin
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 6;
        default: idle_pct = 25;
      endcase
    end
    if (cycle_cnt > LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // input driver
  always @(negedge clk) begin : driver
    operand_t op;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (operand_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (in_taken_cnt < total_items - TAIL && $urandom_range(0, 99) < idle_pct) begin
        gap_left = $urandom_range(0, 11);
        in_valid <= 1'b0;
      end else begin
        op = operand_q.pop_front();
        in_valid <= 1'b1;
        in_base_value <= op.base_value;
        in_exponent <= op.exponent;
        in_modulus <= op.modulus;
      end
    end
  end

  // result stall, with one long hold-off to back up the input side
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && in_taken_cnt >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (out_cnt < total_items - TAIL && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: predict on input item, check on result item
  always @(posedge clk) begin : monitor
    operand_t op;
    power_t   want;
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        op.base_value = in_base_value;
        op.exponent = in_exponent;
        op.modulus = in_modulus;
        power_q.push_back(mod_pow(op));
        in_taken_cnt++;
      end
      if (out_valid && !out_stall) begin
        out_cnt++;
        if (power_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected item, expected none, actual %h / %b", $time,
                   out_power_result, out_zero_modulus_error);
        end else begin
          want = power_q.pop_front();
          if (out_power_result !== want.power_result) begin
            err_cnt++;
            $display("%0t: power_result mismatch, expected %h, actual %h", $time,
                     want.power_result, out_power_result);
          end
          if (out_zero_modulus_error !== want.zero_modulus_error) begin
            err_cnt++;
            $display("%0t: zero_modulus_error mismatch, expected %b, actual %b", $time,
                     want.zero_modulus_error, out_zero_modulus_error);
          end
        end
      end
    end
  end

endmodule

/* modular_exponentiation_unit.f */
sv/mexp_pkg.sv
sv/mexp_mulmod.sv
sv/mexp_seq.sv
sv/modular_exponentiation_unit.sv
dv/tb_top.sv
